### rtl/sparse_edge_list_inference_macros.svh
// Assertion macros shared by the sparse edge-list inference RTL.
`ifndef SPARSE_EDGE_LIST_INFERENCE_MACROS_SVH
`define SPARSE_EDGE_LIST_INFERENCE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SEL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sel_pkg.sv
// Package with the types and constants of the sparse edge-list inference block.
package sel_pkg;

    localparam int NEURON_W    = 12;
    localparam int LANE_FLD_W  = 3;
    localparam int DATA_W      = 32;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_EDGE  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NEURONS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 2'd1;

    localparam logic [CFG_DATA_W-1:0] NEURONS_RST  = 13'd4096;
    localparam logic [CFG_DATA_W-1:0] FEATURES_RST = 13'd1024;

    localparam logic signed [DATA_W-1:0] RELU_MAX = 32'sh0020_0000;

    typedef struct packed {
        mode_t                    mode;
        logic [NEURON_W-1:0]      feature_index;
        logic [LANE_FLD_W-1:0]    lane;
        logic signed [DATA_W-1:0] feature_value;
        logic [NEURON_W-1:0]      source_neuron;
        logic [NEURON_W-1:0]      dest_neuron;
        logic signed [DATA_W-1:0] edge_weight;
        logic                     apply_relu;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] output_value;
        logic [NEURON_W-1:0]      output_feature;
        logic [LANE_FLD_W-1:0]    output_lane;
    } out_t;

    typedef struct packed {
        logic mul_en;
        logic src_ok;
        logic relu;
    } mac_cmd_t;

endpackage

### rtl/sel_ram.sv
// Generic RAM with one write port and two registered read ports.
module sel_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/sel_mac.sv
// Shared multiply, accumulate and clamp unit used once per lane of an edge.
module sel_mac (
    input  logic                              clk,
    input  sel_pkg::mac_cmd_t                 cmd,
    input  logic signed [sel_pkg::DATA_W-1:0] src_data,
    input  logic signed [sel_pkg::DATA_W-1:0] dst_data,
    input  logic signed [sel_pkg::DATA_W-1:0] weight,
    output logic signed [sel_pkg::DATA_W-1:0] result
);

    localparam int SUM_W = 2 * sel_pkg::DATA_W - 15;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN  = SUM_W'(-64'sh0000_0000_8000_0000);
    localparam logic signed [SUM_W-1:0] RELU_TOP = SUM_W'(sel_pkg::RELU_MAX);

    logic signed [2*sel_pkg::DATA_W-1:0] product_reg;
    logic signed [sel_pkg::DATA_W-1:0]   src_eff;
    logic signed [SUM_W-1:0]             sum;

    assign src_eff = cmd.src_ok ? src_data : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            product_reg <= src_eff * weight;
        end
    end

    always_comb
    begin
        sum = SUM_W'(dst_data) + SUM_W'(product_reg >>> 16);
        if (cmd.relu)
        begin
            if (sum < 0)
            begin
                result = '0;
            end
            else if (sum > RELU_TOP)
            begin
                result = sel_pkg::RELU_MAX;
            end
            else
            begin
                result = sum[sel_pkg::DATA_W-1:0];
            end
        end
        else
        begin
            if (sum > SUM_MAX)
            begin
                result = SUM_MAX[sel_pkg::DATA_W-1:0];
            end
            else if (sum < SUM_MIN)
            begin
                result = SUM_MIN[sel_pkg::DATA_W-1:0];
            end
            else
            begin
                result = sum[sel_pkg::DATA_W-1:0];
            end
        end
    end

endmodule

### rtl/sparse_edge_list_inference.sv
// Top level of the sparse edge-list inference engine with its sequencer.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------
//  in      | in_valid / in_ready    | in_data  (sel_pkg::in_t)
//  out     | out_valid / out_ready  | out_data (sel_pkg::out_t)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// After reset and after each clear transaction the memory is swept to zero, one
// word a cycle; no input is taken meanwhile. An edge transaction steps through
// the issue, multiply and accumulate states for each lane: each lane reads the
// source and destination words, multiplies in the shared unit, then adds,
// clamps and writes. A read waits in its done state while the output register
// waits for out_ready. Configuration writes are taken in every cycle.
`include "sparse_edge_list_inference_macros.svh"

module sparse_edge_list_inference #(
    parameter int MAX_NEURONS = 4096,
    parameter int LANES       = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sel_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sel_pkg::out_t                       out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sel_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sel_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH  = MAX_NEURONS * LANES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int RD_W   = sel_pkg::CFG_DATA_W + 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_READ_ISSUE,
        ST_READ_DONE,
        ST_E_ISSUE,
        ST_E_MUL,
        ST_E_ACC
    } state_t;

    state_t                              state_reg, state_next;
    logic [ADDR_W-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [LANE_W-1:0]                   lane_cnt_reg, lane_cnt_next;
    logic [sel_pkg::NEURON_W-1:0]        src_reg, src_next;
    logic [sel_pkg::NEURON_W-1:0]        dst_reg, dst_next;
    logic signed [sel_pkg::DATA_W-1:0]   weight_reg, weight_next;
    logic                                relu_reg, relu_next;
    logic                                src_ok_reg, src_ok_next;
    logic [ADDR_W-1:0]                   addr_reg, addr_next;
    logic [sel_pkg::DATA_W-1:0]          wdata_reg, wdata_next;
    logic                                load_ok_reg, load_ok_next;
    logic                                read_ok_reg, read_ok_next;
    logic [sel_pkg::NEURON_W-1:0]        feat_reg, feat_next;
    logic [sel_pkg::LANE_FLD_W-1:0]      lane_reg, lane_next;
    logic                                out_valid_reg, out_valid_next;
    sel_pkg::out_t                       out_data_reg, out_data_next;
    logic [sel_pkg::CFG_DATA_W-1:0]      neurons_reg, features_reg;

    logic                                ram_we;
    logic [ADDR_W-1:0]                   ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [sel_pkg::DATA_W-1:0]          ram_wdata, ram_rdata_a, ram_rdata_b;
    logic [ADDR_W-1:0]                   src_word, dst_word;
    logic signed [RD_W-1:0]              rd_neuron;
    logic                                in_lane_ok;
    logic                                in_feat_ok;
    logic                                in_dst_ok;
    logic                                rd_neuron_ok;
    sel_pkg::mac_cmd_t                   mac_cmd;
    logic signed [sel_pkg::DATA_W-1:0]   mac_result;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [31:0] neuron,
                                                    input logic [31:0] ln);
        return ADDR_W'(neuron * LANES + ln);
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neurons_reg  <= sel_pkg::NEURONS_RST;
            features_reg <= sel_pkg::FEATURES_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sel_pkg::CFG_NEURONS:  neurons_reg  <= cfg_data;
                sel_pkg::CFG_FEATURES: features_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_lane_ok = (32'(in_data.lane) < LANES);
    assign in_feat_ok = (32'(in_data.feature_index) < MAX_NEURONS);
    assign in_dst_ok  = (32'(in_data.dest_neuron) < MAX_NEURONS);
    assign rd_neuron  = $signed({2'b00, neurons_reg}) - $signed({2'b00, features_reg})
                        + $signed({3'b000, in_data.feature_index});
    assign rd_neuron_ok = !rd_neuron[RD_W-1]
                          && (32'(rd_neuron[RD_W-2:0]) < MAX_NEURONS);

    assign src_word = word_addr(32'(src_reg), 32'(lane_cnt_reg));
    assign dst_word = word_addr(32'(dst_reg), 32'(lane_cnt_reg));

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        lane_cnt_next  = lane_cnt_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        weight_next    = weight_reg;
        relu_next      = relu_reg;
        src_ok_next    = src_ok_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        load_ok_next   = load_ok_reg;
        read_ok_next   = read_ok_reg;
        feat_next      = feat_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.mode)
                        sel_pkg::MODE_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end
                        sel_pkg::MODE_LOAD:
                        begin
                            addr_next    = word_addr(32'(in_data.feature_index),
                                                     32'(in_data.lane));
                            wdata_next   = in_data.feature_value;
                            load_ok_next = in_feat_ok && in_lane_ok;
                            state_next   = ST_LOAD;
                        end
                        sel_pkg::MODE_EDGE:
                        begin
                            src_next      = in_data.source_neuron;
                            dst_next      = in_data.dest_neuron;
                            weight_next   = in_data.edge_weight;
                            relu_next     = in_data.apply_relu;
                            src_ok_next   = (32'(in_data.source_neuron) < MAX_NEURONS);
                            lane_cnt_next = '0;
                            state_next    = in_dst_ok ? ST_E_ISSUE : ST_IDLE;
                        end
                        sel_pkg::MODE_READ:
                        begin
                            addr_next    = word_addr(32'(rd_neuron[RD_W-2:0]),
                                                     32'(in_data.lane));
                            read_ok_next = rd_neuron_ok && in_lane_ok;
                            feat_next    = in_data.feature_index;
                            lane_next    = in_data.lane;
                            state_next   = ST_READ_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
            end
            ST_READ_ISSUE:
            begin
                state_next = ST_READ_DONE;
            end
            ST_READ_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.output_value   = read_ok_reg ? ram_rdata_a : '0;
                    out_data_next.output_feature = feat_reg;
                    out_data_next.output_lane    = lane_reg;
                    state_next                   = ST_IDLE;
                end
            end
            ST_E_ISSUE:
            begin
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                state_next = ST_E_ACC;
            end
            ST_E_ACC:
            begin
                lane_cnt_next = lane_cnt_reg + 1'b1;
                if (lane_cnt_reg == LANE_W'(LANES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_E_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            lane_cnt_reg  <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            weight_reg    <= '0;
            relu_reg      <= 1'b0;
            src_ok_reg    <= 1'b0;
            addr_reg      <= '0;
            wdata_reg     <= '0;
            load_ok_reg   <= 1'b0;
            read_ok_reg   <= 1'b0;
            feat_reg      <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            lane_cnt_reg  <= lane_cnt_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            weight_reg    <= weight_next;
            relu_reg      <= relu_next;
            src_ok_reg    <= src_ok_next;
            addr_reg      <= addr_next;
            wdata_reg     <= wdata_next;
            load_ok_reg   <= load_ok_next;
            read_ok_reg   <= read_ok_next;
            feat_reg      <= feat_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_LOAD:
            begin
                ram_we    = load_ok_reg;
                ram_waddr = addr_reg;
                ram_wdata = wdata_reg;
            end
            ST_E_ACC:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_word;
                ram_wdata = mac_result;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_waddr = dst_word;
                ram_wdata = mac_result;
            end
        endcase
    end

    assign ram_raddr_a = (state_reg == ST_READ_ISSUE || state_reg == ST_READ_DONE)
                         ? addr_reg : src_word;
    assign ram_raddr_b = dst_word;

    assign mac_cmd.mul_en = (state_reg == ST_E_MUL);
    assign mac_cmd.src_ok = src_ok_reg;
    assign mac_cmd.relu   = relu_reg;

    sel_ram #(
        .WIDTH (sel_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    sel_mac u_mac (
        .clk      (clk),
        .cmd      (mac_cmd),
        .src_data (ram_rdata_a),
        .dst_data (ram_rdata_b),
        .weight   (weight_reg),
        .result   (mac_result)
    );

    `SEL_ASSERT_NOW(a_idle_no_write, in_ready, !ram_we, "memory written while idle")
    `SEL_ASSERT_NOW(a_clear_zero, state_reg == ST_CLEAR, ram_we && ram_wdata == '0,
        "clear sweep does not write zero")
    `SEL_ASSERT_NOW(a_result_from_read, $rose(out_valid),
        $past(state_reg) == ST_READ_DONE, "result raised without a read")
    `SEL_ASSERT_NEXT(a_edge_lane_start,
        in_valid && in_ready && in_data.mode == sel_pkg::MODE_EDGE && in_dst_ok,
        lane_cnt_reg == '0 && state_reg == ST_E_ISSUE, "edge does not start at lane zero")

endmodule
